// File: rtl/rrd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrd_pkg
// Shared constants and types of the read response deframer.
// ----------------------------------------------------------------------------
package rrd_pkg;

    localparam int BYTE_W = 8;
    localparam int POS_W  = 9;

    localparam logic [BYTE_W-1:0] HDR_BYTE0 = 8'he0;
    localparam logic [BYTE_W-1:0] HDR_BYTE1 = 8'ha5;
    localparam logic [BYTE_W-1:0] HDR_BYTE2 = 8'h01;
    localparam logic [BYTE_W-1:0] XOR_SEED  = 8'hff;
    localparam logic [BYTE_W-1:0] HDR_LEN   = 8'd4;

    localparam logic ACTION_START = 1'b0;
    localparam logic ACTION_BYTE  = 1'b1;

    localparam logic [1:0] PH_IDLE   = 2'd0;
    localparam logic [1:0] PH_HEADER = 2'd1;
    localparam logic [1:0] PH_BODY   = 2'd2;
    localparam logic [1:0] PH_PAD    = 2'd3;

    localparam logic [1:0] ST_OK         = 2'd0;
    localparam logic [1:0] ST_BAD_HEADER = 2'd1;
    localparam logic [1:0] ST_CHECKSUM   = 2'd2;

    localparam logic [1:0] HDR_POS0 = 2'd0;
    localparam logic [1:0] HDR_POS1 = 2'd1;
    localparam logic [1:0] HDR_POS2 = 2'd2;

    typedef struct packed {
        logic              has_result;
        logic              is_status;
        logic [BYTE_W-1:0] payload_byte;
        logic [BYTE_W-1:0] payload_offset;
        logic [1:0]        status_code;
    } rrd_result_t;

endpackage

// File: rtl/read_response_deframer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// read_response_deframer
// Byte stream parser for memory-read response frames.
//
// Input stream: tuser = 0 arms the parser with the payload length in
// tdata[7:0]; tuser = 1 delivers one frame byte in tdata[15:8]. A frame is
// e0 a5 01, length, payload, checksum, then pad bytes to a multiple of eight.
// Output stream: one transfer per payload byte (tuser = 0) with its offset,
// and one status transfer (tuser = 1, tlast = 1) at the checksum byte or on
// a header mismatch. Items that cause no result produce no transfer.
// Path: a result passes through the input register, then the result
// register. Throughput: one transfer per cycle on both sides while no held
// result blocks the next item; the parser takes one step per item.
// Reset: parser idle, checksum seed loaded, both registers empty.
// Stall: a held result blocks the next item only if that item also makes a
// result; tready then drops after one further item is buffered.
// ----------------------------------------------------------------------------
module read_response_deframer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // expected_length[7:0], rx_byte[15:8]
    input  logic        s_axis_tuser,   // action[0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [23:0] m_axis_tdata,   // payload_byte[7:0], payload_offset[15:8],
                                        // status_code[17:16], zero[23:18]
    output logic        m_axis_tuser,   // is_status[0]
    output logic        m_axis_tlast
);
    import rrd_pkg::*;

    logic              in_valid_reg;
    logic              in_action_reg;
    logic [BYTE_W-1:0] in_len_reg;
    logic [BYTE_W-1:0] in_byte_reg;

    logic              out_valid_reg, out_valid_next;
    logic              out_status_reg;
    logic [BYTE_W-1:0] out_byte_reg;
    logic [BYTE_W-1:0] out_offset_reg;
    logic [1:0]        out_code_reg;

    rrd_result_t       res;
    logic              advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_axis_tready || !res.has_result);
    assign s_axis_tready = !in_valid_reg || advance;

    rrd_parser u_parser
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .step_en         (advance),
        .action          (in_action_reg),
        .expected_length (in_len_reg),
        .rx_byte         (in_byte_reg),
        .result          (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_action_reg <= s_axis_tuser;
            in_len_reg    <= s_axis_tdata[7:0];
            in_byte_reg   <= s_axis_tdata[15:8];
        end
    end

    always_comb
    begin
        if (advance && res.has_result)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance && res.has_result)
        begin
            out_status_reg <= res.is_status;
            out_byte_reg   <= res.payload_byte;
            out_offset_reg <= res.payload_offset;
            out_code_reg   <= res.status_code;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'b0, out_code_reg, out_offset_reg, out_byte_reg};
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_status_reg;

    a_no_result_on_start: assert property (@(posedge clk) disable iff (!rst_n)
        advance && (in_action_reg == ACTION_START) |-> !res.has_result)
        else $error("start item produced a result");

    a_payload_code_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[17:16] == ST_OK)
        else $error("payload transfer carries a status code");

    a_code_legal: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[17:16] != 2'd3)
        else $error("illegal status code");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> in_valid_reg && out_valid_reg && !m_axis_tready)
        else $error("input stalled without a blocked result");

endmodule

// File: rtl/rrd_parser.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrd_parser
// Frame state, header check, payload tagging and checksum of one item.
// ----------------------------------------------------------------------------
module rrd_parser
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       step_en,
    input  logic                       action,
    input  logic [rrd_pkg::BYTE_W-1:0] expected_length,
    input  logic [rrd_pkg::BYTE_W-1:0] rx_byte,
    output rrd_pkg::rrd_result_t       result
);
    import rrd_pkg::*;

    logic [1:0]        phase_reg, phase_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [BYTE_W-1:0] want_reg, want_next;
    logic [BYTE_W-1:0] xor_reg, xor_next;

    logic [POS_W-1:0]  pos_inc;
    logic [POS_W-1:0]  body_end;
    logic [BYTE_W-1:0] xor_upd;
    logic [BYTE_W-1:0] expect_byte;

    assign pos_inc  = pos_reg + POS_W'(1);
    assign body_end = POS_W'(HDR_LEN) + POS_W'(want_reg);
    assign xor_upd  = xor_reg ^ rx_byte;

    always_comb
    begin
        case (pos_reg[1:0])
            HDR_POS0: expect_byte = HDR_BYTE0;
            HDR_POS1: expect_byte = HDR_BYTE1;
            HDR_POS2: expect_byte = HDR_BYTE2;
            default:  expect_byte = want_reg;
        endcase
    end

    always_comb
    begin
        phase_next = phase_reg;
        pos_next   = pos_reg;
        want_next  = want_reg;
        xor_next   = xor_reg;
        result     = '0;
        if (action == ACTION_START)
        begin
            phase_next = PH_HEADER;
            pos_next   = '0;
            want_next  = expected_length;
            xor_next   = XOR_SEED;
        end
        else
        begin
            unique case (phase_reg)
                PH_HEADER:
                begin
                    if (rx_byte != expect_byte)
                    begin
                        phase_next         = PH_IDLE;
                        pos_next           = '0;
                        result.has_result  = 1'b1;
                        result.is_status   = 1'b1;
                        result.status_code = ST_BAD_HEADER;
                    end
                    else
                    begin
                        if (pos_reg >= POS_W'(2))
                            xor_next = xor_upd;
                        pos_next = pos_inc;
                        if (pos_reg >= POS_W'(3))
                            phase_next = PH_BODY;
                    end
                end
                PH_BODY:
                begin
                    xor_next = xor_upd;
                    pos_next = pos_inc;
                    result.has_result = 1'b1;
                    if (pos_reg < body_end)
                    begin
                        result.payload_byte   = rx_byte;
                        result.payload_offset = pos_reg[BYTE_W-1:0] - HDR_LEN;
                    end
                    else
                    begin
                        result.is_status   = 1'b1;
                        result.status_code = (xor_upd == '0) ? ST_OK : ST_CHECKSUM;
                        if (pos_inc[2:0] == 3'd0)
                        begin
                            phase_next = PH_IDLE;
                            pos_next   = '0;
                        end
                        else
                        begin
                            phase_next = PH_PAD;
                        end
                    end
                end
                PH_PAD:
                begin
                    pos_next = pos_inc;
                    if (pos_inc[2:0] == 3'd0)
                    begin
                        phase_next = PH_IDLE;
                        pos_next   = '0;
                    end
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            pos_reg   <= '0;
            want_reg  <= '0;
            xor_reg   <= XOR_SEED;
        end
        else if (step_en)
        begin
            phase_reg <= phase_next;
            pos_reg   <= pos_next;
            want_reg  <= want_next;
            xor_reg   <= xor_next;
        end
    end

endmodule

// File: tb/rrd_deframe_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrd_deframe_checker
// Watches both stream ports of the read response deframer. Every input
// transfer advances a local frame parser that queues the payload and status
// transfers it should cause. Every output transfer is compared field by
// field with the oldest queued one. Reports a running failure count and the
// number of output transfers still owed.
// ----------------------------------------------------------------------------
module rrd_deframe_checker
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // expected_length[7:0], rx_byte[15:8]
    input  logic        s_axis_tuser,   // action[0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [23:0] m_axis_tdata,   // payload_byte[7:0], payload_offset[15:8],
                                        // status_code[17:16], zero[23:18]
    input  logic        m_axis_tuser,   // is_status[0]
    input  logic        m_axis_tlast,
    output int          fail_count,
    output int          pending
);
    import rrd_pkg::*;

    typedef struct packed {
        logic              is_status;
        logic [BYTE_W-1:0] data_byte;
        logic [BYTE_W-1:0] offset;
        logic [1:0]        status;
        logic              last;
    } deframed_t;

    deframed_t         deframed_q[$];
    logic [1:0]        parse_phase = PH_IDLE;
    logic [POS_W-1:0]  frame_pos   = '0;
    logic [BYTE_W-1:0] armed_len   = '0;
    logic [BYTE_W-1:0] running_xor = XOR_SEED;
    int                errs        = 0;

    task automatic parse_transfer(input logic act, input logic [BYTE_W-1:0] len,
                                  input logic [BYTE_W-1:0] rx);
        logic [BYTE_W-1:0] hdr_want;
        logic [POS_W-1:0]  rel;
        if (act == ACTION_START) begin
            parse_phase = PH_HEADER;
            frame_pos   = '0;
            armed_len   = len;
            running_xor = XOR_SEED;
        end else begin
            case (parse_phase)
                PH_HEADER: begin
                    if (frame_pos == POS_W'(HDR_POS0))
                        hdr_want = HDR_BYTE0;
                    else if (frame_pos == POS_W'(HDR_POS1))
                        hdr_want = HDR_BYTE1;
                    else if (frame_pos == POS_W'(HDR_POS2))
                        hdr_want = HDR_BYTE2;
                    else
                        hdr_want = armed_len;
                    if (rx != hdr_want) begin
                        parse_phase = PH_IDLE;
                        frame_pos   = '0;
                        deframed_q.push_back('{1'b1, 8'h00, 8'h00, ST_BAD_HEADER, 1'b1});
                    end else begin
                        if (frame_pos >= POS_W'(HDR_POS2))
                            running_xor = running_xor ^ rx;
                        if (frame_pos >= POS_W'(HDR_LEN - 8'd1))
                            parse_phase = PH_BODY;
                        frame_pos = frame_pos + POS_W'(1);
                    end
                end
                PH_BODY: begin
                    running_xor = running_xor ^ rx;
                    if (frame_pos < POS_W'(HDR_LEN) + POS_W'(armed_len)) begin
                        rel = frame_pos - POS_W'(HDR_LEN);
                        frame_pos = frame_pos + POS_W'(1);
                        deframed_q.push_back('{1'b0, rx, rel[BYTE_W-1:0], ST_OK, 1'b0});
                    end else begin
                        frame_pos = frame_pos + POS_W'(1);
                        if (frame_pos[2:0] == 3'd0) begin
                            parse_phase = PH_IDLE;
                            frame_pos   = '0;
                        end else begin
                            parse_phase = PH_PAD;
                        end
                        deframed_q.push_back('{1'b1, 8'h00, 8'h00,
                            (running_xor == 8'h00) ? ST_OK : ST_CHECKSUM, 1'b1});
                    end
                end
                PH_PAD: begin
                    frame_pos = frame_pos + POS_W'(1);
                    if (frame_pos[2:0] == 3'd0) begin
                        parse_phase = PH_IDLE;
                        frame_pos   = '0;
                    end
                end
                default: ;
            endcase
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : watch
        deframed_t got;
        deframed_t want;
        if (!rst_n) begin
            parse_phase = PH_IDLE;
            frame_pos   = '0;
            armed_len   = '0;
            running_xor = XOR_SEED;
            deframed_q.delete();
            pending    <= 0;
            fail_count <= errs;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                got = '{m_axis_tuser, m_axis_tdata[7:0], m_axis_tdata[15:8],
                        m_axis_tdata[17:16], m_axis_tlast};
                if (deframed_q.size() == 0) begin
                    errs++;
                    $error("unexpected output transfer: tdata %h tuser %b tlast %b",
                           m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end else begin
                    want = deframed_q.pop_front();
                    if (got.is_status !== want.is_status) begin
                        errs++;
                        $error("is_status: expected %0d, got %0d",
                               want.is_status, got.is_status);
                    end
                    if (got.data_byte !== want.data_byte) begin
                        errs++;
                        $error("payload_byte: expected %0h, got %0h",
                               want.data_byte, got.data_byte);
                    end
                    if (got.offset !== want.offset) begin
                        errs++;
                        $error("payload_offset: expected %0d, got %0d",
                               want.offset, got.offset);
                    end
                    if (got.status !== want.status) begin
                        errs++;
                        $error("status_code: expected %0d, got %0d",
                               want.status, got.status);
                    end
                    if (got.last !== want.last) begin
                        errs++;
                        $error("last: expected %0d, got %0d", want.last, got.last);
                    end
                    if (m_axis_tdata[23:18] !== 6'd0) begin
                        errs++;
                        $error("tdata pad: expected 0, got %0h", m_axis_tdata[23:18]);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                parse_transfer(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8]);
            pending    <= deframed_q.size();
            fail_count <= errs;
        end
    end

endmodule

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the read response deframer. Sends a directed set
// of frames covering idle bytes, a frame ending on an eight-byte boundary, a
// bad checksum, a restart mid-frame and a header mismatch, then random clean,
// corrupted and cut frames with random idling on both ports. One long
// receiver hold-off forces input backpressure, and one sender pause drains
// all results. A cycle watchdog guards against hangs.
// ----------------------------------------------------------------------------
module tb;
    import rrd_pkg::*;

    localparam int ITEMS       = 500;
    localparam int HOLD_CYCLES = 200;
    localparam int STALL_LIMIT = 2000;
    localparam int SETTLE      = 8;

    typedef enum int {
        FRAME_CLEAN,
        FRAME_BAD_HEADER,
        FRAME_BAD_SUM,
        FRAME_CUT
    } frame_fault_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;
    logic        s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic        m_axis_tuser;
    logic        m_axis_tlast;

    int fail_count;
    int pending;
    int sent          = 0;
    int stall_cycles  = 0;
    bit quiet         = 1'b0;
    bit hold_off_req  = 1'b0;

    read_response_deframer u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    rrd_deframe_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .fail_count    (fail_count),
        .pending       (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic offer(input logic act, input logic [7:0] len, input logic [7:0] rx,
                         input bit counted = 1'b1);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= act;
        s_axis_tdata  <= {rx, len};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (counted)
            sent++;
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge clk);
        end
    endtask

    task automatic offer_frame(input logic [7:0] len, input frame_fault_t fault);
        logic [7:0] frame_q[$];
        logic [7:0] sum;
        logic [7:0] val;
        int         keep;
        int         k;
        frame_q = '{HDR_BYTE0, HDR_BYTE1, HDR_BYTE2, len};
        sum = XOR_SEED ^ HDR_BYTE2 ^ len;
        for (k = 0; k < int'(len); k++) begin
            val = 8'($urandom);
            frame_q.push_back(val);
            sum = sum ^ val;
        end
        if (fault == FRAME_BAD_SUM)
            sum = sum ^ 8'($urandom_range(1, 255));
        frame_q.push_back(sum);
        while (frame_q.size() % 8 != 0)
            frame_q.push_back(8'($urandom));
        keep = frame_q.size();
        if (fault == FRAME_BAD_HEADER) begin
            k = $urandom_range(0, 3);
            frame_q[k] = frame_q[k] ^ 8'($urandom_range(1, 255));
            keep = k + 1;
        end else if (fault == FRAME_CUT) begin
            keep = $urandom_range(1, frame_q.size() - 1);
        end
        while (frame_q.size() > keep)
            void'(frame_q.pop_back());
        offer(ACTION_START, len, 8'($urandom));
        foreach (frame_q[i])
            offer(ACTION_BYTE, 8'($urandom), frame_q[i]);
        // trailing bytes after a header mismatch land on an idle parser
        if (fault == FRAME_BAD_HEADER)
            repeat ($urandom_range(0, 2)) offer(ACTION_BYTE, 8'($urandom), 8'($urandom), 1'b0);
    endtask

    initial begin : watchdog
        while (stall_cycles < STALL_LIMIT) begin
            @(posedge clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("Regression FAIL");
        $finish;
    end

    initial begin : sink_side
        m_axis_tready <= 1'b0;
        @(posedge clk);
        while (rst_n !== 1'b1)
            @(posedge clk);
        forever begin
            if (hold_off_req) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_off_req = 1'b0;
            end else if (!quiet && $urandom_range(0, 7) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge clk);
            end
        end
    end

    initial begin : source_side
        int         pick;
        bit         drained;
        bit         big_done;
        logic [7:0] len;
        drained  = 1'b0;
        big_done = 1'b0;
        rst_n         <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= 1'b0;
        s_axis_tdata  <= '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // idle byte, then a frame that ends on an eight-byte boundary
        offer(ACTION_BYTE, 8'hff, 8'hff, 1'b0);
        offer(ACTION_START, 8'd3, 8'h00);
        offer(ACTION_BYTE, 8'h00, HDR_BYTE0);
        offer(ACTION_BYTE, 8'h00, HDR_BYTE1);
        offer(ACTION_BYTE, 8'h00, HDR_BYTE2);
        offer(ACTION_BYTE, 8'h00, 8'd3);
        offer(ACTION_BYTE, 8'h00, 8'h00);
        offer(ACTION_BYTE, 8'h00, 8'hff);
        offer(ACTION_BYTE, 8'h00, 8'h80);
        offer(ACTION_BYTE, 8'h00, XOR_SEED ^ HDR_BYTE2 ^ 8'd3 ^ 8'h00 ^ 8'hff ^ 8'h80);
        offer_frame(8'd0, FRAME_BAD_SUM);
        // restart mid-frame, then a header mismatch, then an idle byte
        offer(ACTION_START, 8'hff, 8'hff);
        offer(ACTION_BYTE, 8'h00, HDR_BYTE0);
        offer(ACTION_START, 8'd0, 8'h00);
        offer(ACTION_BYTE, 8'h00, 8'he1);
        offer(ACTION_BYTE, 8'h00, 8'h00, 1'b0);

        while (sent < ITEMS) begin
            if (!big_done && sent > ITEMS / 4) begin
                hold_off_req = 1'b1;
                offer_frame(8'd255, FRAME_CLEAN);
                big_done = 1'b1;
            end
            if (!drained && sent > ITEMS / 2) begin
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                while (pending != 0)
                    @(posedge clk);
                drained = 1'b1;
            end
            if (sent > ITEMS * 85 / 100)
                quiet = 1'b1;
            len = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(13, 60))
                                              : 8'($urandom_range(0, 12));
            pick = $urandom_range(0, 99);
            if (pick < 65)
                offer_frame(len, FRAME_CLEAN);
            else if (pick < 77)
                offer_frame(len, FRAME_BAD_HEADER);
            else if (pick < 87)
                offer_frame(len, FRAME_BAD_SUM);
            else if (pick < 95)
                offer_frame(len, FRAME_CUT);
            else
                repeat ($urandom_range(1, 3))
                    offer(ACTION_BYTE, 8'($urandom), 8'($urandom), 1'b0);
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
